FILE: hw/rtl/pearson_correlation_top_macros.svh
// Assertion macros shared by the correlation block's RTL files.
// Depends on nothing; each macro samples on clock and is disabled in reset.
`ifndef PEARSON_CORRELATION_TOP_MACROS_SVH
`define PEARSON_CORRELATION_TOP_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define PCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define PCC_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/pcc_pkg.sv
// Types and constants of the correlation block.
// Used by the controller, the datapath and the top level.
package pcc_pkg;

   localparam int ACC_W       = 64;
   localparam int MUL_STEPS   = 64;
   localparam int ROOT_STEPS  = 32;
   localparam int DIV_STEPS   = 15;
   localparam int NUM_PRODS   = 6;
   localparam int ONE_Q       = 16384;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_DEGEN    = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef enum logic [3:0] {
      ST_ACC, ST_MLOAD, ST_MRUN, ST_FORM, ST_SLOAD, ST_SRUN,
      ST_DMUL, ST_DLOAD, ST_DRUN, ST_FIN, ST_OUT
   } pcc_state_type;

   typedef struct packed {
      logic       clear;
      logic       acc;
      logic       mul_load;
      logic       mul_step;
      logic [2:0] mul_sel;
      logic       form;
      logic       sqrt_load;
      logic       sqrt_step;
      logic       dmul;
      logic       div_load;
      logic       div_step;
      logic       finish;
   } pcc_cmd_type;

   typedef struct packed {
      logic full;
      logic overflow;
   } pcc_stat_type;

endpackage

FILE: hw/rtl/pcc_ctrl.sv
// Sequencer of the correlation block: accepts words, then steps the datapath
// through products, roots and division. Depends on pcc_pkg and the macros header.
`include "pearson_correlation_top_macros.svh"

module pcc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  pcc_pkg::pcc_stat_type stat,
   output pcc_pkg::pcc_cmd_type  cmd
);
   import pcc_pkg::*;

   pcc_state_type state_ff, state_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [2:0]    sel_ff, sel_in;
   logic          take;

   assign take = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACC;
         cnt_ff   <= '0;
         sel_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_ACC: begin
            sel_in = '0;
            if (take && req_tlast) begin
               state_in = ST_MLOAD;
            end
         end
         ST_MLOAD: begin
            cnt_in   = '0;
            state_in = ST_MRUN;
         end
         ST_MRUN: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) begin
               if (sel_ff == 3'(NUM_PRODS - 1)) begin
                  state_in = ST_FORM;
               end else begin
                  sel_in   = sel_ff + 3'd1;
                  state_in = ST_MLOAD;
               end
            end
         end
         ST_FORM:  state_in = ST_SLOAD;
         ST_SLOAD: begin
            cnt_in   = '0;
            state_in = ST_SRUN;
         end
         ST_SRUN: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(ROOT_STEPS - 1)) begin
               state_in = ST_DMUL;
            end
         end
         ST_DMUL:  state_in = ST_DLOAD;
         ST_DLOAD: begin
            cnt_in   = '0;
            state_in = ST_DRUN;
         end
         ST_DRUN: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:   state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_ACC;
            end
         end
         default:  state_in = ST_ACC;
      endcase
   end

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = sel_ff;
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      case (state_ff)
         ST_ACC: begin
            // The input is always ready here, so a valid word is taken.
            req_tready = 1'b1;
            cmd.acc    = req_tvalid;
         end
         ST_MLOAD: cmd.mul_load  = 1'b1;
         ST_MRUN:  cmd.mul_step  = 1'b1;
         ST_FORM:  cmd.form      = 1'b1;
         ST_SLOAD: cmd.sqrt_load = 1'b1;
         ST_SRUN:  cmd.sqrt_step = 1'b1;
         ST_DMUL:  cmd.dmul      = 1'b1;
         ST_DLOAD: cmd.div_load  = 1'b1;
         ST_DRUN:  cmd.div_step  = 1'b1;
         ST_FIN:   cmd.finish    = 1'b1;
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            cmd.clear  = rsp_tready;
         end
         default: cmd = '0;
      endcase
   end

   `PCC_ASSERT(a_last_starts_products, (take && req_tlast) |=> (state_ff == ST_MLOAD),
               "last word did not start the products")
   `PCC_ASSERT(a_clear_only_on_delivery, cmd.clear |-> (rsp_tvalid && rsp_tready),
               "sums cleared without a delivered word")
   `PCC_ASSERT(a_no_accept_while_result, rsp_tvalid |-> !req_tready,
               "word accepted while a result waits")
   `PCC_ASSERT(a_overflow_needs_full, $rose(stat.overflow) |-> $past(stat.full),
               "overflow flagged below capacity")

endmodule

FILE: hw/rtl/pcc_dp.sv
// Datapath of the correlation block: running sums, a bit-serial multiplier,
// two digit-by-digit square roots and a restoring divider. Depends on pcc_pkg.
`include "pearson_correlation_top_macros.svh"

module pcc_dp #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pcc_pkg::pcc_cmd_type  cmd,
   input  logic [15:0]          sample_a,
   input  logic [15:0]          sample_b,
   output pcc_pkg::pcc_stat_type stat,
   output logic [15:0]          correlation,
   output logic [1:0]           status
);
   import pcc_pkg::*;

   localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam logic [ACC_W-1:0] MASK = (64'd1 << SAMPLE_BITS) - 64'd1;

   logic [CNT_W-1:0] cnt_ff;
   logic             ovf_ff;
   logic [ACC_W-1:0] sa_ff, sb_ff, saa_ff, sbb_ff, sab_ff;
   logic [ACC_W-1:0] a64, b64, raw_a, raw_b;
   logic signed [24:0] a25, b25;
   logic signed [49:0] paa, pbb, pab;

   logic [ACC_W-1:0] prod_ff [NUM_PRODS];
   logic [ACC_W-1:0] mx_ff, my_ff, opx, opy;

   logic [ACC_W-1:0] va_ff, vb_ff, mag_ff, num;
   logic             neg_ff;
   logic [ACC_W-1:0] xa_ff, ra_ff, xb_ff, rb_ff, bit_ff, ta, tb;
   logic [ACC_W-1:0] d_ff, r_ff, dr;
   logic [14:0]      q_ff;
   logic             sat_ff;
   logic [15:0]      qr, qmag;
   logic             degen;
   logic [15:0]      corr_ff;
   logic [1:0]       status_ff;

   // The low SAMPLE_BITS bits of each sample are two's complement.
   assign raw_a = {48'd0, sample_a};
   assign raw_b = {48'd0, sample_b};
   assign a64   = (raw_a & MASK) | (raw_a[SAMPLE_BITS-1] ? ~MASK : '0);
   assign b64   = (raw_b & MASK) | (raw_b[SAMPLE_BITS-1] ? ~MASK : '0);
   assign a25   = a64[24:0];
   assign b25   = b64[24:0];
   assign paa   = a25 * a25;
   assign pbb   = b25 * b25;
   assign pab   = a25 * b25;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
         sa_ff  <= '0;
         sb_ff  <= '0;
         saa_ff <= '0;
         sbb_ff <= '0;
         sab_ff <= '0;
      end else if (cmd.acc) begin
         if (cnt_ff == CNT_W'(MAX_SAMPLES)) begin
            ovf_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
            sa_ff  <= sa_ff + a64;
            sb_ff  <= sb_ff + b64;
            saa_ff <= saa_ff + {{14{paa[49]}}, paa};
            sbb_ff <= sbb_ff + {{14{pbb[49]}}, pbb};
            sab_ff <= sab_ff + {{14{pab[49]}}, pab};
         end
      end
   end

   assign stat.full     = (cnt_ff == CNT_W'(MAX_SAMPLES));
   assign stat.overflow = ovf_ff;

   always_comb begin
      case (cmd.mul_sel)
         3'd0:    begin opx = ACC_W'(cnt_ff); opy = sab_ff; end
         3'd1:    begin opx = sa_ff;          opy = sb_ff;  end
         3'd2:    begin opx = ACC_W'(cnt_ff); opy = saa_ff; end
         3'd3:    begin opx = sa_ff;          opy = sa_ff;  end
         3'd4:    begin opx = ACC_W'(cnt_ff); opy = sbb_ff; end
         3'd5:    begin opx = sb_ff;          opy = sb_ff;  end
         default: begin opx = '0;             opy = '0;     end
      endcase
   end

   // Shift-and-add product modulo 2^64, one multiplier bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         mx_ff                  <= opx;
         my_ff                  <= opy;
         prod_ff[cmd.mul_sel]   <= '0;
      end else if (cmd.mul_step) begin
         mx_ff <= mx_ff << 1;
         my_ff <= my_ff >> 1;
         if (my_ff[0]) begin
            prod_ff[cmd.mul_sel] <= prod_ff[cmd.mul_sel] + mx_ff;
         end
      end
   end

   assign num = prod_ff[0] - prod_ff[1];

   always_ff @(posedge clock) begin
      if (cmd.form) begin
         va_ff  <= prod_ff[2] - prod_ff[3];
         vb_ff  <= prod_ff[4] - prod_ff[5];
         neg_ff <= num[ACC_W-1];
         mag_ff <= num[ACC_W-1] ? (64'd0 - num) : num;
      end
   end

   assign ta = ra_ff + bit_ff;
   assign tb = rb_ff + bit_ff;

   // Both floor roots run side by side, two radicand bits per cycle.
   always_ff @(posedge clock) begin
      if (cmd.sqrt_load) begin
         xa_ff  <= va_ff;
         xb_ff  <= vb_ff;
         ra_ff  <= '0;
         rb_ff  <= '0;
         bit_ff <= 64'd1 << 62;
      end else if (cmd.sqrt_step) begin
         if (xa_ff >= ta) begin
            xa_ff <= xa_ff - ta;
            ra_ff <= (ra_ff >> 1) + bit_ff;
         end else begin
            ra_ff <= ra_ff >> 1;
         end
         if (xb_ff >= tb) begin
            xb_ff <= xb_ff - tb;
            rb_ff <= (rb_ff >> 1) + bit_ff;
         end else begin
            rb_ff <= rb_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign dr = d_ff - r_ff;

   always_ff @(posedge clock) begin
      if (cmd.dmul) begin
         d_ff <= ra_ff[31:0] * rb_ff[31:0];
      end
      if (cmd.div_load) begin
         r_ff   <= mag_ff;
         q_ff   <= '0;
         sat_ff <= (mag_ff >= d_ff);
      end else if (cmd.div_step) begin
         if (r_ff >= dr) begin
            r_ff <= r_ff - dr;
            q_ff <= {q_ff[13:0], 1'b1};
         end else begin
            r_ff <= r_ff << 1;
            q_ff <= {q_ff[13:0], 1'b0};
         end
      end
   end

   assign qr    = ({1'b0, q_ff} + 16'd1) >> 1;
   assign qmag  = (sat_ff || qr > 16'(ONE_Q)) ? 16'(ONE_Q) : qr;
   assign degen = (va_ff == '0) || (vb_ff == '0) || (d_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         corr_ff   <= degen ? '0 : (neg_ff ? (16'd0 - qmag) : qmag);
         status_ff <= ovf_ff ? STATUS_OVERFLOW : (degen ? STATUS_DEGEN : STATUS_OK);
      end
   end

   assign correlation = corr_ff;
   assign status      = status_ff;

   `PCC_NEVER(a_count_in_range, cnt_ff > CNT_W'(MAX_SAMPLES), "pair count beyond capacity")
   `PCC_ASSERT(a_full_sets_overflow, (cmd.acc && stat.full) |=> ovf_ff, "pair past capacity not flagged")
   `PCC_ASSERT(a_clear_empties, cmd.clear |=> (cnt_ff == '0 && !ovf_ff), "clear left a count behind")

endmodule

FILE: hw/rtl/pearson_correlation_top.sv
// Top level of the Pearson correlation block.
// Instantiates pcc_ctrl and pcc_dp; depends on pcc_pkg.
//
// Usage: each req word carries one sample pair, sample_a in req_tdata[15:0]
// and sample_b in req_tdata[31:16]; req_tlast marks the final pair of a set.
// Pairs are taken one per cycle while the block accumulates. After the word
// with req_tlast the block stops taking words and evaluates the set:
// six 64-bit products one after another in the bit-serial multiplier, then
// the variances are formed, the two square roots taken side by side, their
// product formed, the division run and the quotient rounded. The single result
// word then sits on rsp_* (correlation in Q1.14 in rsp_tdata, status in
// rsp_tuser) until rsp_tready takes it; while the receiver stalls, no new
// pair is accepted. Taking the result clears the sums and reopens the
// input. Pairs beyond MAX_SAMPLES are dropped and the set reports
// status 2. Reset (synchronous) clears all sums and the count.
// The throughput is set by the shared serial multiplier.

module pearson_correlation_top #(
   parameter int MAX_SAMPLES = 4096,
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] req_tdata,   // sample_a [15:0], sample_b [31:16]
   input  logic        req_tlast,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic [15:0] rsp_tdata,   // correlation [15:0]
   output logic [1:0]  rsp_tuser,   // status [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready
);
   import pcc_pkg::*;

   pcc_cmd_type  cmd;
   pcc_stat_type stat;

   pcc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   pcc_dp #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sample_a    (req_tdata[15:0]),
      .sample_b    (req_tdata[31:16]),
      .stat        (stat),
      .correlation (rsp_tdata),
      .status      (rsp_tuser)
   );

endmodule

FILE: test/pearson_correlation_top_test.sv
// Testbench of the Pearson correlation block: random and directed sets of sample pairs.
// Depends on pcc_pkg and pearson_correlation_top; predicts each result in place.
`timescale 1ns / 100ps

module pearson_correlation_top_test;
   import pcc_pkg::*;

   localparam int CAPACITY = 4096;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct {
      logic [15:0] correlation;
      logic [1:0]  status;
   } corr_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;

   pearson_correlation_top DUT (
      .clock(clock), .reset(reset),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   always #1 clock = ~clock;

   // Running sums of the set being collected, as the block keeps them.
   int unsigned pair_count;
   logic [63:0] acc_a, acc_b, acc_aa, acc_bb, acc_ab;
   bit          dropped_pair;
   corr_result_type pending_results[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatch_count = 0;
   longint      cycle_count = 0;

   function automatic logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic void clear_sums();
      pair_count = 0;
      acc_a = 0; acc_b = 0; acc_aa = 0; acc_bb = 0; acc_ab = 0;
      dropped_pair = 0;
   endfunction

   // Takes one accepted pair into the sums and, on the last one, queues the coefficient.
   function automatic void accumulate_pair(logic [15:0] a_raw, logic [15:0] b_raw, bit is_last);
      logic [63:0] a, b, n, num, va, vb, mag, d, q, r;
      bit neg, degen;
      corr_result_type res;
      if (pair_count < CAPACITY) begin
         a = {{48{a_raw[15]}}, a_raw};
         b = {{48{b_raw[15]}}, b_raw};
         acc_a += a; acc_b += b;
         acc_aa += a * a; acc_bb += b * b; acc_ab += a * b;
         pair_count++;
      end else begin
         dropped_pair = 1;
      end
      if (!is_last) return;
      n = pair_count;
      num = n * acc_ab - acc_a * acc_b;
      va = n * acc_aa - acc_a * acc_a;
      vb = n * acc_bb - acc_b * acc_b;
      neg = num[63];
      mag = neg ? -num : num;
      degen = (va == 0 || vb == 0);
      d = 0;
      if (!degen) begin
         d = floor_root(va) * floor_root(vb);
         if (d == 0) degen = 1;
      end
      q = 0;
      if (!degen) begin
         if (mag >= d) begin
            q = ONE_Q;
         end else begin
            r = mag;
            for (int i = 0; i < 15; i++) begin
               if (r >= d - r) begin
                  r = r - (d - r);
                  q = (q << 1) | 1;
               end else begin
                  r = r << 1;
                  q = q << 1;
               end
            end
            q = (q + 1) >> 1;
            if (q > ONE_Q) q = ONE_Q;
         end
      end
      res.correlation = neg ? 16'(-q) : 16'(q);
      res.status = dropped_pair ? STATUS_OVERFLOW : (degen ? STATUS_DEGEN : STATUS_OK);
      pending_results = {pending_results, res};
      clear_sums();
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      corr_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Unexpected result word: corr %0d status %0d",
                        $signed(rsp_tdata), rsp_tuser);
         end else begin
            want = pending_results.pop_front();
            if (want.correlation !== rsp_tdata || want.status !== rsp_tuser) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected corr %0d status %0d, got corr %0d status %0d",
                           $signed(want.correlation), want.status,
                           $signed(rsp_tdata), rsp_tuser);
            end
         end
      end
   end

   // Offers one pair and holds it until the block accepts it.
   task automatic send_pair(logic [15:0] a, logic [15:0] b, bit is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tdata <= {b, a};
      req_tlast <= is_last;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accumulate_pair(a, b, is_last);
   endtask

   task automatic stop_sending();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic [15:0] random_sample(int style);
      case (style)
         0: return 16'($urandom);
         1: return 16'($urandom_range(15)) - 16'd8;
         2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
         default: return 16'($urandom_range(2000)) - 16'd1000;
      endcase
   endfunction

   task automatic test_edge_values();
      send_pair(16'h0005, 16'h0007, 1);           // one pair: degenerate
      send_pair(16'h0003, 16'h0001, 0);           // constant a: degenerate
      send_pair(16'h0003, 16'hFFF0, 1);
      send_pair(16'h7FFF, 16'h7FFF, 0);           // perfect positive at extremes
      send_pair(16'h8000, 16'h8000, 1);
      send_pair(16'h7FFF, 16'h8000, 0);           // perfect negative
      send_pair(16'h8000, 16'h7FFF, 1);
      send_pair(16'h0001, 16'h0002, 0);
      send_pair(16'h0002, 16'h0001, 0);
      send_pair(16'h0003, 16'h0005, 0);
      send_pair(16'hFFFF, 16'h0000, 1);
      send_pair(16'h5555, 16'hAAAA, 0);
      send_pair(16'hAAAA, 16'h5555, 0);
      send_pair(16'h0000, 16'hFFFF, 1);
      stop_sending();
      wait_drained();
   endtask

   // Fills the store beyond capacity so the set reports status 2.
   task automatic test_capacity_overflow();
      for (int i = 0; i < CAPACITY + 2; i++)
         send_pair(16'($urandom), 16'($urandom), i == CAPACITY + 1);
      stop_sending();
      wait_drained();
   endtask

   task automatic test_random_sets(int pairs_total);
      int sent, len, style;
      sent = 0;
      while (sent < pairs_total) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(12, 1);
         style = $urandom_range(3);
         for (int i = 0; i < len; i++) begin
            send_pair(random_sample(style), random_sample($urandom_range(3) == 0 ? 0 : style),
                      i == len - 1);
            sent++;
         end
      end
      stop_sending();
      wait_drained();
   endtask

   initial begin
      clear_sums();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_edge_values();
      test_capacity_overflow();
      send_idle_pct = 15; recv_idle_pct = 66;
      test_random_sets(650);
      send_idle_pct = 66; recv_idle_pct = 15;
      test_random_sets(650);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random_sets(650);
      repeat (600) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
